@@ hdl/ffn_pkg.sv @@
// ffn_pkg: types, constants and the rounding threshold table of the
// frequency normalizer. No dependencies.
`default_nettype none

package ffn_pkg;

	localparam int FREQ_W     = 32;
	localparam int TL_W       = 4;
	localparam int SYM_W      = 8;
	localparam int CNT_W      = 16;
	localparam int STEP_W     = 63;
	localparam int REM_W      = 18;
	localparam int CORR_W     = 20;
	localparam int THR_W      = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int CQ_DEPTH   = 4;
	localparam int RQ_DEPTH   = 16;

	localparam int SCALE_BASE = 62;
	localparam int RND_SHIFT  = 20;
	localparam int RND_LIMIT  = 8;
	localparam int CNT_MAX    = 32768;

	localparam logic [FREQ_W-1:0] TC_RESET = 32'd1;
	localparam logic [TL_W-1:0]   TL_RESET = 4'd11;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOG   = 1'b1;

	localparam logic signed [REM_W:0] REM_FLOOR = (REM_W+1)'(-(2**(REM_W-1)));

	typedef struct packed {
		logic [FREQ_W-1:0] frequency;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [CNT_W-1:0] count;
		logic             is_correction;
		logic             correction_ok;
		logic             done_res;
	} result_t;

	typedef struct packed {
		logic [FREQ_W-1:0] frequency;
		logic [SYM_W-1:0]  symbol;
		logic              last;
		logic              first;
	} cmd_t;

	typedef enum logic {
		BK_RUN,
		BK_DIV
	} back_state_t;

	function automatic logic [THR_W-1:0] round_thresh(input logic [2:0] p);
		logic [THR_W-1:0] t;
		case (p)
			3'd1: t = 20'd473195;
			3'd2: t = 20'd504333;
			3'd3: t = 20'd520860;
			3'd4: t = 20'd550000;
			3'd5: t = 20'd700000;
			3'd6: t = 20'd750000;
			3'd7: t = 20'd830000;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

@@ hdl/ffn_front.sv @@
// ffn_front: accepts frequency items, numbers them within a set, marks set
// start and end, and buffers them in a short command queue.
// Depends on ffn_pkg.
`default_nettype none

module ffn_front import ffn_pkg::*; #(
	parameter int MAX_SYMBOLS = 256
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	output logic  full,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_pop
);

	localparam int CQ_AW = $clog2(CQ_DEPTH);

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wptr_q;
	logic [CQ_AW-1:0] rptr_q;
	logic [CQ_AW:0]   fill_q;
	logic [SYM_W-1:0] sym_q;
	logic             first_q;
	logic             accept;
	cmd_t             cmd_in;

	assign full      = (fill_q == (CQ_AW+1)'(CQ_DEPTH));
	assign accept    = push && !full;
	assign cmd_valid = (fill_q != '0);
	assign cmd       = mem_q[rptr_q];

	always_comb begin
		cmd_in.frequency = item.frequency;
		cmd_in.symbol    = sym_q;
		cmd_in.first     = first_q;
		cmd_in.last      = item.last ||
			({1'b0, sym_q} >= (SYM_W+1)'(MAX_SYMBOLS - 1));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			fill_q  <= '0;
			sym_q   <= '0;
			first_q <= 1'b1;
		end else begin
			if (accept) begin
				wptr_q <= wptr_q + CQ_AW'(1);
				if (cmd_in.last) begin
					sym_q   <= '0;
					first_q <= 1'b1;
				end else begin
					sym_q   <= sym_q + SYM_W'(1);
					first_q <= 1'b0;
				end
			end
			if (cmd_pop) begin
				rptr_q <= rptr_q + CQ_AW'(1);
			end
			case ({accept, cmd_pop})
				2'b10: fill_q <= fill_q + (CQ_AW+1)'(1);
				2'b01: fill_q <= fill_q - (CQ_AW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/ffn_div.sv @@
// ffn_div: bit-serial restoring divider for the reciprocal step
// 2^62 / divisor, one quotient bit per cycle. Depends on ffn_pkg.
`default_nettype none

module ffn_div import ffn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FREQ_W-1:0] divisor,
	output logic              done,
	output logic [STEP_W-1:0] quotient
);

	localparam int IDX_W = $clog2(STEP_W);

	logic              busy_q;
	logic              done_q;
	logic [IDX_W-1:0]  idx_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] div_q;
	logic [STEP_W-1:0] quo_q;
	logic              num_bit;
	logic [FREQ_W:0]   trial;
	logic [FREQ_W:0]   diff;
	logic              ge;

	assign num_bit  = (idx_q == IDX_W'(STEP_W - 1));
	assign trial    = {rem_q, num_bit};
	assign ge       = (trial >= {1'b0, div_q});
	assign diff     = trial - {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= IDX_W'(STEP_W - 1);
			end else if (busy_q) begin
				if (idx_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= (divisor == '0) ? FREQ_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			quo_q <= {quo_q[STEP_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

@@ hdl/ffn_back.sv @@
// ffn_back: issues queued commands, runs the share pipeline, tracks the
// remaining total and largest share, and holds the result queue.
// Depends on ffn_pkg and ffn_div.
`default_nettype none

module ffn_back import ffn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [FREQ_W-1:0] total_count,
	input  logic [TL_W-1:0]   table_log,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output result_t           result
);

	localparam int RQ_AW = $clog2(RQ_DEPTH);
	localparam int SC_W  = 6;

	back_state_t       state_q;
	back_state_t       state_d;
	logic              div_start;
	logic              div_done;
	logic [STEP_W-1:0] div_quo;
	logic              issue;
	logic              step_valid_q;
	logic [STEP_W-1:0] step_q;
	logic [RQ_AW:0]    resv_q;
	logic              credit_ok;

	// stage 1: low partial product
	logic              v_s1;
	logic [FREQ_W-1:0] freq_s1;
	logic [SYM_W-1:0]  sym_s1;
	logic              last_s1;
	logic              first_s1;
	logic [TL_W-1:0]   tl_s1;
	logic [STEP_W-33:0] sh_s1;
	logic [63:0]       plo_s1;
	logic [63:0]       plo_c;

	// stage 2: high partial product
	logic              v_s2;
	logic [SYM_W-1:0]  sym_s2;
	logic              last_s2;
	logic              first_s2;
	logic [TL_W-1:0]   tl_s2;
	logic [63:0]       plo_s2;
	logic [STEP_W-1:0] phi_s2;
	logic [STEP_W-1:0] phi_c;

	// stage 3: full product and overflow
	logic              v_s3;
	logic [SYM_W-1:0]  sym_s3;
	logic              last_s3;
	logic              first_s3;
	logic [TL_W-1:0]   tl_s3;
	logic              ovf_s3;
	logic [STEP_W-1:0] lo_s3;
	logic [94:0]       prod_c;

	// stage 4: shift down
	logic              v_s4;
	logic [SYM_W-1:0]  sym_s4;
	logic              last_s4;
	logic              first_s4;
	logic [TL_W-1:0]   tl_s4;
	logic              ovf_s4;
	logic [CNT_W-1:0]  proba_s4;
	logic [STEP_W-1:0] rem_s4;
	logic [SC_W-1:0]   bshift_s4;
	logic [SC_W-1:0]   scale_c;
	logic [STEP_W-1:0] shifted_c;
	logic [STEP_W-1:0] mask_c;

	// stage 5: rounding
	logic              v_s5;
	logic [SYM_W-1:0]  sym_s5;
	logic              last_s5;
	logic              first_s5;
	logic [TL_W-1:0]   tl_s5;
	logic [CNT_W-1:0]  count_s5;
	logic [STEP_W-1:0] beat_c;
	logic              up_c;
	logic [CNT_W-1:0]  count_c;

	// set tracking
	logic signed [REM_W-1:0] rem_q;
	logic [CNT_W-1:0]        lg_share_q;
	logic [SYM_W-1:0]        lg_sym_q;
	logic [CNT_W-1:0]        pow_tl;
	logic signed [REM_W:0]   rem_base;
	logic signed [REM_W:0]   rem_diff;
	logic signed [REM_W-1:0] rem_new;
	logic [CNT_W-1:0]        lg_share_base;
	logic [SYM_W-1:0]        lg_sym_base;
	logic [CNT_W-1:0]        lg_share_new;
	logic [SYM_W-1:0]        lg_sym_new;
	logic signed [CORR_W-1:0] share_x;
	logic signed [CORR_W-1:0] rem_x;
	logic signed [CORR_W-1:0] half_x;
	logic signed [CORR_W-1:0] corr_x;
	logic                    fix_ok;
	logic [CNT_W-1:0]        fix_cnt;

	// result queue
	result_t          rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0] rq_wptr_q;
	logic [RQ_AW-1:0] rq_rptr_q;
	logic [RQ_AW:0]   rq_fill_q;
	logic             res_take;
	result_t          res_cnt;
	result_t          res_fix;
	logic [RQ_AW:0]   issue_n;
	logic [RQ_AW:0]   write_n;

	ffn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (total_count),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign credit_ok = (resv_q <= (RQ_AW+1)'(RQ_DEPTH - 2));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_RUN: if (div_start) state_d = BK_DIV;
			BK_DIV: if (div_done) state_d = BK_RUN;
			default: state_d = BK_RUN;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		issue     = 1'b0;
		if (state_q == BK_RUN && cmd_valid) begin
			if (cmd.first && !step_valid_q) begin
				div_start = 1'b1;
			end else if (credit_ok) begin
				issue = 1'b1;
			end
		end
	end

	assign cmd_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_RUN;
			step_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_done) begin
				step_valid_q <= 1'b1;
			end else if (issue && cmd.last) begin
				step_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			step_q <= div_quo;
		end
	end

	// share pipeline
	assign plo_c = cmd.frequency * step_q[31:0];
	assign phi_c = freq_s1 * sh_s1;
	assign prod_c = {phi_s2, 32'b0} + {31'b0, plo_s2};

	assign scale_c   = SC_W'(SCALE_BASE) - {{(SC_W-TL_W){1'b0}}, tl_s3};
	assign shifted_c = lo_s3 >> scale_c;
	assign mask_c    = ~({STEP_W{1'b1}} << scale_c);

	assign beat_c  = {{(STEP_W-THR_W){1'b0}}, round_thresh(proba_s4[2:0])} << bshift_s4;
	assign up_c    = (proba_s4 < CNT_W'(RND_LIMIT)) && (rem_s4 > beat_c);
	assign count_c = ovf_s4 ? (CNT_W'(1) << tl_s4) : (proba_s4 + CNT_W'(up_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		freq_s1  <= cmd.frequency;
		sym_s1   <= cmd.symbol;
		last_s1  <= cmd.last;
		first_s1 <= cmd.first;
		tl_s1    <= table_log;
		sh_s1    <= step_q[STEP_W-1:32];
		plo_s1   <= plo_c;

		sym_s2   <= sym_s1;
		last_s2  <= last_s1;
		first_s2 <= first_s1;
		tl_s2    <= tl_s1;
		plo_s2   <= plo_s1;
		phi_s2   <= phi_c;

		sym_s3   <= sym_s2;
		last_s3  <= last_s2;
		first_s3 <= first_s2;
		tl_s3    <= tl_s2;
		ovf_s3   <= (|prod_c[94:63]) || (prod_c[62] && (|prod_c[61:0]));
		lo_s3    <= prod_c[STEP_W-1:0];

		sym_s4    <= sym_s3;
		last_s4   <= last_s3;
		first_s4  <= first_s3;
		tl_s4     <= tl_s3;
		ovf_s4    <= ovf_s3;
		proba_s4  <= shifted_c[CNT_W-1:0];
		rem_s4    <= lo_s3 & mask_c;
		bshift_s4 <= scale_c - SC_W'(RND_SHIFT);

		sym_s5   <= sym_s4;
		last_s5  <= last_s4;
		first_s5 <= first_s4;
		tl_s5    <= tl_s4;
		count_s5 <= count_c;
	end

	// remaining total, largest share and the closing correction
	assign pow_tl   = CNT_W'(1) << tl_s5;
	assign rem_base = first_s5 ? $signed({{(REM_W+1-CNT_W){1'b0}}, pow_tl})
	                           : $signed({rem_q[REM_W-1], rem_q});
	assign rem_diff = rem_base - $signed({{(REM_W+1-CNT_W){1'b0}}, count_s5});
	assign rem_new  = (rem_diff < REM_FLOOR) ? REM_FLOOR[REM_W-1:0] : rem_diff[REM_W-1:0];

	assign lg_share_base = first_s5 ? '0 : lg_share_q;
	assign lg_sym_base   = first_s5 ? '0 : lg_sym_q;
	assign lg_share_new  = (count_s5 > lg_share_base) ? count_s5 : lg_share_base;
	assign lg_sym_new    = (count_s5 > lg_share_base) ? sym_s5 : lg_sym_base;

	assign share_x = $signed({{(CORR_W-CNT_W){1'b0}}, lg_share_new});
	assign rem_x   = $signed({{(CORR_W-REM_W){rem_new[REM_W-1]}}, rem_new});
	assign half_x  = $signed({{(CORR_W-CNT_W+1){1'b0}}, lg_share_new[CNT_W-1:1]});
	assign corr_x  = share_x + rem_x;
	assign fix_ok  = (-rem_x) <= half_x;

	always_comb begin
		if (corr_x < 0) begin
			fix_cnt = '0;
		end else if (corr_x > $signed(CORR_W'(CNT_MAX))) begin
			fix_cnt = CNT_W'(CNT_MAX);
		end else begin
			fix_cnt = corr_x[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			lg_share_q <= '0;
			lg_sym_q   <= '0;
		end else if (v_s5) begin
			rem_q      <= rem_new;
			lg_share_q <= lg_share_new;
			lg_sym_q   <= lg_sym_new;
		end
	end

	// result queue, two writes when a set closes
	always_comb begin
		res_cnt.symbol        = sym_s5;
		res_cnt.count         = count_s5;
		res_cnt.is_correction = 1'b0;
		res_cnt.correction_ok = 1'b0;
		res_cnt.done_res      = 1'b0;
		res_fix.symbol        = lg_sym_new;
		res_fix.count         = fix_cnt;
		res_fix.is_correction = 1'b1;
		res_fix.correction_ok = fix_ok;
		res_fix.done_res      = 1'b1;
	end

	assign empty    = (rq_fill_q == '0);
	assign result   = rq_q[rq_rptr_q];
	assign res_take = pop && !empty;
	assign issue_n  = issue ? (cmd.last ? (RQ_AW+1)'(2) : (RQ_AW+1)'(1)) : '0;
	assign write_n  = v_s5 ? (last_s5 ? (RQ_AW+1)'(2) : (RQ_AW+1)'(1)) : '0;

	always_ff @(posedge clk) begin
		if (v_s5) begin
			rq_q[rq_wptr_q] <= res_cnt;
			if (last_s5) begin
				rq_q[rq_wptr_q + RQ_AW'(1)] <= res_fix;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wptr_q <= '0;
			rq_rptr_q <= '0;
			rq_fill_q <= '0;
			resv_q    <= '0;
		end else begin
			rq_wptr_q <= rq_wptr_q + write_n[RQ_AW-1:0];
			if (res_take) begin
				rq_rptr_q <= rq_rptr_q + RQ_AW'(1);
			end
			rq_fill_q <= rq_fill_q + write_n - (RQ_AW+1)'(res_take);
			resv_q    <= resv_q + issue_n - (RQ_AW+1)'(res_take);
		end
	end

endmodule

`default_nettype wire

@@ hdl/fse_fast_frequency_normalizer.sv @@
// fse_fast_frequency_normalizer: top level of the streaming frequency
// normalizer; holds the configuration registers and joins front and back.
// Depends on ffn_pkg, ffn_front, ffn_back.
//
//  channel  | ports                        | transfer when
//  ---------+------------------------------+-----------------------
//  config   | cfg_we, cfg_idx, cfg_data    | cfg_we high
//  items    | push, full, item             | push && !full
//  results  | empty, pop, result           | pop && !empty
//
// One item per cycle sustained while full stays low; a count result passes the command
// queue, the share pipeline and the result queue, and a closing item's correction is
// written with it, next in line. The first item of each set waits for the bit-serial
// reciprocal divider, which runs 63 iterations. Reset clears control only; no
// clearing pass. With pop low the 16-entry result queue fills, then the 4-entry
// command queue, then full rises.
`default_nettype none

module fse_fast_frequency_normalizer import ffn_pkg::*; #(
	parameter int MAX_SYMBOLS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  item_t                 item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result
);

	logic [FREQ_W-1:0] total_count_q;
	logic [TL_W-1:0]   table_log_q;
	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_count_q <= TC_RESET;
			table_log_q   <= TL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TOTAL_COUNT: total_count_q <= cfg_data[FREQ_W-1:0];
				CFG_TABLE_LOG:   table_log_q   <= cfg_data[TL_W-1:0];
				default: ;
			endcase
		end
	end

	ffn_front #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ffn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.total_count (total_count_q),
		.table_log   (table_log_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

`default_nettype wire

@@ hdl/ffn_checker.sv @@
// ffn_checker: port-level checks of the normalizer's result stream, bound
// to the top level. Depends on ffn_pkg and fse_fast_frequency_normalizer.
`default_nettype none

module ffn_checker import ffn_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before transfer");

	a_fix_closes: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.is_correction == result.done_res))
		else $error("correction and set end disagree");

	a_ok_only_fix: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_correction) |-> !result.correction_ok)
		else $error("ok flag on a count result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.count <= CNT_W'(CNT_MAX)))
		else $error("count above table size limit");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("result present right after reset");

endmodule

bind fse_fast_frequency_normalizer ffn_checker u_ffn_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

@@ tb/fse_fast_frequency_normalizer_tb.sv @@
// Self-checking testbench for fse_fast_frequency_normalizer: directed table, then random
// symbol sets, checked against an in-bench model of the share and correction math.
// Depends on ffn_pkg and the DUT; needs no files or arguments.
`timescale 1ns / 1ps

module fse_fast_frequency_normalizer_tb;
	import ffn_pkg::*;

	localparam int MAX_SYMBOLS   = 256;
	localparam int RECIP_SHIFT   = 62;
	localparam int ROUND_SHIFT   = 20;
	localparam int DEFICIT_FLOOR = -131072;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 500;

	typedef enum logic {ROW_WRITE, ROW_FREQ} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [31:0]           value;
		bit                    last;
		bit                    typed;
		logic [CNT_W-1:0]      share;
		logic [SYM_W-1:0]      fix_sym;
		logic [CNT_W-1:0]      fix_count;
		bit                    fix_ok;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  push;
	item_t                 item;
	logic                  full;
	logic                  empty;
	logic                  pop;
	result_t               result;

	// model state
	logic [31:0]      cfg_total;
	logic [TL_W-1:0]  cfg_tl;
	logic [62:0]      step_q;
	bit               step_ok;
	logic [SYM_W-1:0] sym_q;
	int               remain_q;
	logic [SYM_W-1:0] big_sym;
	int unsigned      big_share;

	result_t     pending_counts[$];
	result_t     oldest;
	row_t        plan[$];
	int          n_errors;
	int          quiet_cycles;
	int          pop_hold;
	bit          idle_on;

	fse_fast_frequency_normalizer #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (item),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	always #5 clk = ~clk;

	function automatic int unsigned round_bar(logic [2:0] p);
		case (p)
			3'd1: return 473195;
			3'd2: return 504333;
			3'd3: return 520860;
			3'd4: return 550000;
			3'd5: return 700000;
			3'd6: return 750000;
			3'd7: return 830000;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned share_for(logic [31:0] f, logic [TL_W-1:0] tl);
		logic [94:0] prod;
		logic [63:0] frac;
		logic [63:0] bar;
		int unsigned shift;
		int unsigned p;
		prod = 95'(f) * 95'(step_q);
		if (prod > (95'(1) << RECIP_SHIFT))
			return 32'd1 << tl;
		shift = RECIP_SHIFT - int'(tl);
		p = 32'(prod >> shift);
		frac = 64'(prod & ((95'(1) << shift) - 95'(1)));
		if (p < 8) begin
			bar = (64'(1) << (shift - ROUND_SHIFT)) * 64'(round_bar(p[2:0]));
			if (frac > bar)
				p++;
		end
		return p;
	endfunction

	function automatic void normalize_freq(item_t it);
		logic [TL_W-1:0] tl;
		int unsigned share;
		bit closes;
		bit ok;
		int corr;
		result_t r;
		tl = cfg_tl;
		if (!step_ok) begin
			step_q = 63'(64'h4000_0000_0000_0000 / 64'((cfg_total == 0) ? 32'd1 : cfg_total));
			step_ok = 1'b1;
			sym_q = '0;
			remain_q = 1 << tl;
			big_sym = '0;
			big_share = 0;
		end
		closes = it.last || (sym_q == SYM_W'(MAX_SYMBOLS - 1));
		share = 0;
		if (it.frequency != 0) begin
			share = share_for(it.frequency, tl);
			if (share > big_share) begin
				big_share = share;
				big_sym = sym_q;
			end
			remain_q -= int'(share);
			if (remain_q < DEFICIT_FLOOR)
				remain_q = DEFICIT_FLOOR;
		end
		r = '0;
		r.symbol = sym_q;
		r.count = CNT_W'(share);
		pending_counts.insert(pending_counts.size(), r);
		if (!closes) begin
			sym_q++;
			return;
		end
		ok = -remain_q <= int'(big_share >> 1);
		corr = int'(big_share) + remain_q;
		if (corr < 0)
			corr = 0;
		if (corr > CNT_MAX)
			corr = CNT_MAX;
		r.symbol = big_sym;
		r.count = CNT_W'(corr);
		r.is_correction = 1'b1;
		r.correction_ok = ok;
		r.done_res = 1'b1;
		pending_counts.insert(pending_counts.size(), r);
		step_ok = 1'b0;
		sym_q = '0;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		row_t r;
		r = '{kind: ROW_WRITE, default: '0};
		r.idx = idx;
		r.value = value;
		plan.insert(plan.size(), r);
	endfunction

	function automatic void add_freq(logic [31:0] f, bit last);
		row_t r;
		r = '{kind: ROW_FREQ, default: '0};
		r.value = f;
		r.last = last;
		plan.insert(plan.size(), r);
	endfunction

	function automatic void add_known(logic [31:0] f, bit last, logic [CNT_W-1:0] share,
			logic [SYM_W-1:0] fix_sym, logic [CNT_W-1:0] fix_count, bit fix_ok);
		row_t r;
		r = '{kind: ROW_FREQ, default: '0};
		r.value = f;
		r.last = last;
		r.typed = 1'b1;
		r.share = share;
		r.fix_sym = fix_sym;
		r.fix_count = fix_count;
		r.fix_ok = fix_ok;
		plan.insert(plan.size(), r);
	endfunction

	// entered and left at a falling edge
	task automatic send_item(logic [31:0] f, bit last);
		item_t it;
		it.frequency = f;
		it.last = last;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		normalize_freq(it);
		@(negedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (pending_counts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		if (idx == CFG_TOTAL_COUNT)
			cfg_total = value;
		else
			cfg_tl = value[TL_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_counts.size() == 0) begin
				$error("result with none expected: symbol %0d count %0d",
					result.symbol, result.count);
				n_errors++;
			end else begin
				oldest = pending_counts.pop_front();
				check_field("symbol", oldest.symbol, result.symbol);
				check_field("count", oldest.count, result.count);
				check_field("is_correction", oldest.is_correction, result.is_correction);
				check_field("correction_ok", oldest.correction_ok, result.correction_ok);
				check_field("done_res", oldest.done_res, result.done_res);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		pop = 1'b0;
		pop_hold = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (pop_hold == 0 && idle_on && $urandom_range(0, 4) == 0)
				pop_hold = $urandom_range(1, 3);
			if (pop_hold != 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] f;
		logic [31:0] new_total;
		logic [63:0] set_sum;
		logic [31:0] set_freq[$];
		result_t     fix;
		result_t     cnt;
		int          n_rand;
		int          pick;
		int          n;
		bit          long_done;
		bit          mark_last;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		push = 1'b0;
		item = '0;
		idle_on = 1'b1;
		n_errors = 0;
		quiet_cycles = 0;
		cfg_total = TC_RESET;
		cfg_tl = TL_RESET;
		step_q = '0;
		step_ok = 1'b0;
		sym_q = '0;
		remain_q = 0;
		big_sym = '0;
		big_share = 0;

		// reset values, then the corners of both registers
		add_known(32'd1, 1'b1, 16'd2048, 8'd0, 16'd2048, 1'b1);
		add_write(CFG_TABLE_LOG, 32'd15);
		add_write(CFG_TOTAL_COUNT, 32'hFFFF_FFFF);
		add_known(32'hFFFF_FFFF, 1'b1, 16'd32767, 8'd0, 16'd32768, 1'b1);
		// zero total acts as one; zero frequency; all-zero set
		add_write(CFG_TOTAL_COUNT, 32'd0);
		add_write(CFG_TABLE_LOG, 32'd5);
		add_freq(32'd0, 1'b0);
		add_freq(32'd1, 1'b1);
		add_known(32'd0, 1'b1, 16'd0, 8'd0, 16'd32, 1'b1);
		// share overflow, bound violated
		add_write(CFG_TOTAL_COUNT, 32'd1);
		add_write(CFG_TABLE_LOG, 32'd11);
		add_known(32'hFFFF_FFFF, 1'b0, 16'd2048, 8'd0, 16'd0, 1'b0);
		add_known(32'hFFFF_FFFF, 1'b1, 16'd2048, 8'd0, 16'd0, 1'b0);
		// deficit hits the floor
		add_write(CFG_TABLE_LOG, 32'd15);
		repeat (5) add_known(32'd2, 1'b0, 16'd32768, 8'd0, 16'd0, 1'b0);
		add_known(32'd2, 1'b1, 16'd32768, 8'd0, 16'd0, 1'b0);
		// tiny table log, rounding of small shares
		add_write(CFG_TABLE_LOG, 32'd0);
		add_write(CFG_TOTAL_COUNT, 32'd3);
		add_freq(32'd1, 1'b0);
		add_freq(32'd1, 1'b0);
		add_freq(32'd1, 1'b1);
		add_write(CFG_TABLE_LOG, 32'd5);
		add_write(CFG_TOTAL_COUNT, 32'd1000);
		add_freq(32'd1, 1'b0);
		add_freq(32'd7, 1'b0);
		add_freq(32'd20, 1'b0);
		add_freq(32'd100, 1'b0);
		add_freq(32'd250, 1'b0);
		add_freq(32'd622, 1'b1);
		// registers rewritten in the middle of a set
		add_freq(32'd500, 1'b0);
		add_freq(32'd300, 1'b0);
		add_write(CFG_TABLE_LOG, 32'd8);
		add_write(CFG_TOTAL_COUNT, 32'd5);
		add_freq(32'd200, 1'b1);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[k].idx, plan[k].value);
			end else begin
				send_item(plan[k].value, plan[k].last);
				if (plan[k].typed) begin
					n = pending_counts.size();
					if (plan[k].last) begin
						fix = pending_counts[n-1];
						fix.symbol = plan[k].fix_sym;
						fix.count = plan[k].fix_count;
						fix.correction_ok = plan[k].fix_ok;
						pending_counts[n-1] = fix;
						n--;
					end
					cnt = pending_counts[n-1];
					cnt.count = plan[k].share;
					pending_counts[n-1] = cnt;
				end
			end
		end

		n_rand = 0;
		long_done = 1'b0;
		mark_last = 1'b1;
		while (n_rand < RANDOM_ITEMS) begin
			idle_on = (n_rand < RANDOM_ITEMS - 80) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			if (!long_done && n_rand > 150) begin
				// no last mark: the symbol limit closes the set
				long_done = 1'b1;
				set_freq = {};
				set_sum = '0;
				repeat (MAX_SYMBOLS) begin
					f = $urandom_range(0, 5000);
					set_freq.insert(set_freq.size(), f);
					set_sum += 64'(f);
				end
				mark_last = 1'b0;
				new_total = set_sum[31:0];
			end else if (pick < 3 && set_freq.size() != 0 && set_freq.size() < MAX_SYMBOLS) begin
				new_total = cfg_total;
			end else begin
				set_freq = {};
				set_sum = '0;
				n = (pick == 3) ? $urandom_range(25, 80) : $urandom_range(1, 16);
				repeat (n) begin
					f = ($urandom_range(0, 4) == 0) ? 32'd0 : ($urandom >> $urandom_range(0, 31));
					if (set_sum + 64'(f) > 64'hFFFF_FFFF)
						f = 32'(64'hFFFF_FFFF - set_sum);
					set_freq.insert(set_freq.size(), f);
					set_sum += 64'(f);
				end
				mark_last = 1'b1;
				if (pick == 9)
					new_total = $urandom >> $urandom_range(0, 31);
				else
					new_total = set_sum[31:0];
			end

			if (new_total != cfg_total || $urandom_range(0, 3) == 0) begin
				settle();
				write_reg(CFG_TOTAL_COUNT, new_total);
				if ($urandom_range(0, 2) == 0) begin
					if ($urandom_range(0, 7) == 0)
						write_reg(CFG_TABLE_LOG, $urandom_range(0, 4));
					else
						write_reg(CFG_TABLE_LOG, $urandom_range(5, 15));
				end
			end

			foreach (set_freq[i]) begin
				send_item(set_freq[i], mark_last && (i == set_freq.size() - 1));
				n_rand++;
			end
		end

		push <= 1'b0;
		while (pending_counts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
